FILE: hw/rtl/caller_id_fsk_generator_unit_macros.svh
// assertion macros shared by the caller id fsk generator rtl
`ifndef CALLER_ID_FSK_GENERATOR_UNIT_MACROS_SVH
`define CALLER_ID_FSK_GENERATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CIDG_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cidg assertion failed");
`define CIDG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cidg assertion failed");
`else
`define CIDG_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define CIDG_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/cidg_pkg.sv
// shared types and constants of the caller id fsk generator
package cidg_pkg;
   localparam int OPCODE_W  = 2;
   localparam int CHAR_W    = 8;
   localparam int SAMPLE_W  = 14;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int RATE_W    = 16;
   localparam int FREQ_W    = 12;
   localparam int TIME_W    = 18;
   localparam int COUNT_W   = 19;

   localparam logic [OPCODE_W-1:0] OP_CLEAR         = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_APPEND_NUMBER = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_APPEND_NAME   = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_TICK          = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_FORMAT_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MONTH       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DAY         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HOUR        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MINUTE      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_RATE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MARK_FREQ   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPACE_FREQ  = 3'd7;

   localparam int PREAMBLE_BYTES = 50;
   localparam int FIRST_PREAMBLE = 29;
   localparam logic [7:0] PREAMBLE_A   = 8'h55;
   localparam logic [7:0] PREAMBLE_B   = 8'hFF;
   localparam logic [7:0] ASCII_ZERO   = 8'h30;
   localparam logic [7:0] MDMF_TYPE    = 8'h80;
   localparam logic [7:0] SDMF_TYPE    = 8'h04;
   localparam logic [7:0] PARAM_DATE   = 8'h01;
   localparam logic [7:0] PARAM_NUMBER = 8'h02;
   localparam logic [7:0] PARAM_NAME   = 8'h07;
   localparam logic [7:0] DATE_LEN     = 8'h08;
   localparam int AMPLITUDE = 8191;
endpackage

FILE: hw/rtl/cidg_if.sv
// request and response channel interfaces
interface cidg_req_if;
   logic valid;
   logic ready;
   logic [cidg_pkg::OPCODE_W-1:0] opcode;
   logic [cidg_pkg::CHAR_W-1:0] char_code;
   modport source (output valid, output opcode, output char_code, input ready);
   modport sink (input valid, input opcode, input char_code, output ready);
endinterface

interface cidg_rsp_if;
   logic valid;
   logic ready;
   logic signed [cidg_pkg::SAMPLE_W-1:0] sample_value;
   logic last_sample;
   logic status_code;
   modport source (output valid, output sample_value, output last_sample,
                   output status_code, input ready);
   modport sink (input valid, input sample_value, input last_sample,
                 input status_code, output ready);
endinterface

FILE: hw/rtl/cidg_ram.sv
// generic single write, single registered read ram
module cidg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;
endmodule

FILE: hw/rtl/cidg_divider.sv
// bit-serial restoring divider, one quotient bit per cycle
module cidg_divider #(
   parameter int NUM_W = 40
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [NUM_W-1:0]                 numerator,
   input  logic [cidg_pkg::RATE_W-1:0]      denominator,
   output logic                             busy,
   output logic                             done,
   output logic [NUM_W-1:0]                 quotient
);
   localparam int DenW = cidg_pkg::RATE_W;
   localparam int CntW = $clog2(NUM_W);

   logic [DenW-1:0]  rem_ff, rem_in;
   logic [DenW-1:0]  den_ff, den_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DenW:0]    trial;
   logic [DenW:0]    diff;
   logic             fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      fits    = trial >= {1'b0, den_ff};
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         den_in  = denominator;
         quo_in  = numerator;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DenW-1:0] : trial[DenW-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntW'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

FILE: hw/rtl/cidg_sine_rom.sv
// full-cycle sine lookup built from a quarter-wave constant table
module cidg_sine_rom #(
   parameter int TABLE_BITS = 10
) (
   input  logic [TABLE_BITS-1:0]                index,
   output logic signed [cidg_pkg::SAMPLE_W-1:0] value
);
   localparam int Quarter = (1 << TABLE_BITS) >> 2;
   localparam int QW = TABLE_BITS - 2;
   localparam longint HalfPiQ30 = 64'd1686629713;
   localparam longint TermDiv [7] = '{6, 20, 42, 72, 110, 156, 210};
   localparam int Amplitude = cidg_pkg::AMPLITUDE;

   // taylor series in q30 over the first quadrant
   function automatic logic [12:0] quarter_sin(input int unsigned r);
      logic [63:0] theta;
      logic [63:0] th2;
      logic [63:0] term;
      longint      sum;
      logic [63:0] mag;
      theta = (64'(r) * 64'(HalfPiQ30)) / 64'(Quarter);
      th2   = (theta * theta) >> 30;
      term  = theta;
      sum   = longint'(theta);
      for (int n = 1; n <= 7; n++) begin
         term = ((term * th2) >> 30) / 64'(TermDiv[n-1]);
         if (n % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      mag = (64'(Amplitude) * 64'(sum)) >> 30;
      if (mag > 64'(Amplitude)) begin
         mag = 64'(Amplitude);
      end
      return 13'(mag);
   endfunction

   logic [12:0] quarter_rom [Quarter];

   for (genvar gi = 0; gi < Quarter; gi++) begin : g_rom
      assign quarter_rom[gi] = quarter_sin(gi);
   end

   logic [1:0]    quad;
   logic [QW-1:0] pos;
   logic [QW-1:0] mirror;
   logic [12:0]   mag;

   always_comb begin
      quad   = index[TABLE_BITS-1 -: 2];
      pos    = index[QW-1:0];
      mirror = QW'(0) - pos;
      if (quad[0]) begin
         mag = (pos == '0) ? 13'(Amplitude) : quarter_rom[mirror];
      end else begin
         mag = quarter_rom[pos];
      end
      value = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   end
endmodule

FILE: hw/rtl/caller_id_fsk_generator_unit.sv
// caller id fsk generator top level: sequencer, message builder and timing
// Load number and name characters with append items, then send one tick item
// per audio sample; each tick returns one signed sample of a five-second
// buffer (one second of silence, the 0x55/0xFF preambles, the framed MDMF or
// SDMF message with checksum, then zero padding). Ticks are handled one at a
// time. A silent or padding sample is answered without the divider; a tone
// sample needs two divisions, for the sine phase and the bit timing ratio,
// and at a bit boundary the next bit is fetched, with a third division for
// the rescaled phase when the tone changes. The one shared bit-serial
// divider does these in turn. Appends that fit in the store, clears and
// register writes restart the buffer; a tick with no number loaded returns
// status 1.
`include "caller_id_fsk_generator_unit_macros.svh"
module caller_id_fsk_generator_unit #(
   parameter int STRING_CAPACITY = 32,
   parameter int BIT_RATE        = 1200,
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   cidg_req_if.sink                         req_chan,
   cidg_rsp_if.source                       rsp_chan,
   input  logic                             csr_write_en,
   input  logic [cidg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cidg_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   localparam int LenW   = $clog2(STRING_CAPACITY + 1);
   localparam int AddrW  = $clog2(STRING_CAPACITY);
   localparam int MaxMsg = 17 + 2 * STRING_CAPACITY;
   localparam int MbiW   = $clog2(cidg_pkg::PREAMBLE_BYTES + MaxMsg + 1);
   localparam int NumW   = 30 + SINE_TABLE_BITS;
   localparam int TW     = cidg_pkg::TIME_W;
   localparam int FW     = cidg_pkg::FREQ_W;
   localparam int RW     = cidg_pkg::RATE_W;
   localparam int CW     = cidg_pkg::COUNT_W;
   localparam logic signed [17:0] BitRateS = 18'(BIT_RATE);

   typedef enum logic [11:0] {
      ST_IDLE       = 12'b0000_0000_0001,
      ST_FETCH      = 12'b0000_0000_0010,
      ST_BYTE       = 12'b0000_0000_0100,
      ST_MUL        = 12'b0000_0000_1000,
      ST_TONE_GO    = 12'b0000_0001_0000,
      ST_TONE_WAIT  = 12'b0000_0010_0000,
      ST_RATE_GO    = 12'b0000_0100_0000,
      ST_RATE_WAIT  = 12'b0000_1000_0000,
      ST_MUL_PHASE  = 12'b0001_0000_0000,
      ST_PHASE_GO   = 12'b0010_0000_0000,
      ST_PHASE_WAIT = 12'b0100_0000_0000,
      ST_DONE       = 12'b1000_0000_0000
   } state_type;

   typedef enum logic [2:0] {
      FK_FIRST   = 3'b001,
      FK_ADVANCE = 3'b010,
      FK_NEW     = 3'b100
   } fetch_kind_type;

   // configuration
   logic          format_ff;
   logic [6:0]    month_ff, day_ff, hour_ff, minute_ff;
   logic [RW-1:0] rate_cfg_ff;
   logic [FW-1:0] mark_ff, space_ff;

   // strings and buffer position
   logic [LenW-1:0] num_len_ff, num_len_in;
   logic [LenW-1:0] name_len_ff, name_len_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [MbiW-1:0] mbi_ff, mbi_in;
   logic [3:0]      fbi_ff, fbi_in;
   logic [7:0]      csum_ff, csum_in;
   logic [TW-1:0]   t_ff, t_in;
   logic [7:0]      sib_ff, sib_in;
   logic [15:0]     resid_ff, resid_in;
   logic            cur_ff, cur_in;
   logic            nb_ff, nb_in;
   logic [29:0]     prod_ff, prod_in;
   logic signed [cidg_pkg::SAMPLE_W-1:0] sample_ff, sample_in;
   logic            status_ff, status_in;
   logic            skip_ff, skip_in;
   state_type       state_ff, state_in;
   fetch_kind_type  kind_ff, kind_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic signed [cidg_pkg::SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic            rsp_last_ff, rsp_last_in;
   logic            rsp_status_ff, rsp_status_in;

   logic            req_fire;
   logic            do_restart;

   // string stores
   logic             num_we, name_we;
   logic [AddrW-1:0] num_raddr, name_raddr;
   logic [7:0]       num_rdata, name_rdata;

   // shared divider
   logic             div_start, div_busy, div_done;
   logic [NumW-1:0]  div_num, div_quotient;
   logic [RW-1:0]    div_den;

   logic signed [cidg_pkg::SAMPLE_W-1:0] rom_value;

   // derived values
   logic [RW-1:0]   rate_eff;
   logic [CW-1:0]   total;
   logic [CW-1:0]   count_next;
   logic [MbiW-1:0] msg_len, msg_idx, name_pos, active_end;
   logic            active;
   logic [FW-1:0]   f_cur, f_nb, f_bit;
   logic [2:0]      date_j;
   logic [6:0]      date_v;
   logic [14:0]     date_prod;
   logic [3:0]      date_tens;
   logic [6:0]      date_ones;
   logic [7:0]      date_char;
   logic [7:0]      byte_val;
   logic [7:0]      preamble_pat;
   logic            bit_val;
   logic [3:0]      fbi_inc;
   logic [3:0]      fbi_limit;
   logic signed [17:0] br_val, res_val;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   assign rate_eff   = (rate_cfg_ff == '0) ? RW'(1) : rate_cfg_ff;
   assign total      = CW'({rate_eff, 2'b00}) + CW'(rate_eff);
   assign count_next = count_ff + CW'(1);
   assign msg_len    = format_ff ? MbiW'(11) + MbiW'(num_len_ff)
                     : MbiW'(15) + MbiW'(num_len_ff)
                       + ((name_len_ff != '0) ? MbiW'(name_len_ff) + MbiW'(2) : MbiW'(0));
   assign msg_idx    = mbi_ff - MbiW'(cidg_pkg::PREAMBLE_BYTES);
   assign name_pos   = msg_idx - MbiW'(14) - MbiW'(num_len_ff);
   assign active_end = MbiW'(cidg_pkg::PREAMBLE_BYTES) + msg_len;
   assign active     = (count_ff >= CW'(rate_eff)) && (mbi_ff < active_end);
   assign f_cur      = cur_ff ? mark_ff : space_ff;
   assign f_nb       = nb_ff ? mark_ff : space_ff;
   assign f_bit      = bit_val ? mark_ff : space_ff;

   assign num_raddr  = format_ff ? AddrW'(msg_idx - MbiW'(10)) : AddrW'(msg_idx - MbiW'(14));
   assign name_raddr = AddrW'(name_pos - MbiW'(2));

   assign num_we  = req_fire && (req_chan.opcode == cidg_pkg::OP_APPEND_NUMBER)
                  && (num_len_ff < LenW'(STRING_CAPACITY));
   assign name_we = req_fire && (req_chan.opcode == cidg_pkg::OP_APPEND_NAME)
                  && (name_len_ff < LenW'(STRING_CAPACITY));

   cidg_ram #(.WIDTH(8), .DEPTH(STRING_CAPACITY)) u_number_ram (
      .clock      (clock),
      .write_en   (num_we),
      .write_addr (num_len_ff[AddrW-1:0]),
      .write_data (req_chan.char_code),
      .read_addr  (num_raddr),
      .read_data  (num_rdata)
   );

   cidg_ram #(.WIDTH(8), .DEPTH(STRING_CAPACITY)) u_name_ram (
      .clock      (clock),
      .write_en   (name_we),
      .write_addr (name_len_ff[AddrW-1:0]),
      .write_data (req_chan.char_code),
      .read_addr  (name_raddr),
      .read_data  (name_rdata)
   );

   cidg_divider #(.NUM_W(NumW)) u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (div_num),
      .denominator (div_den),
      .busy        (div_busy),
      .done        (div_done),
      .quotient    (div_quotient)
   );

   cidg_sine_rom #(.TABLE_BITS(SINE_TABLE_BITS)) u_sine_rom (
      .index (div_quotient[SINE_TABLE_BITS-1:0]),
      .value (rom_value)
   );

   // divider operands by phase of the tick
   always_comb begin
      div_start = 1'b0;
      div_num   = NumW'({prod_ff, {SINE_TABLE_BITS{1'b0}}});
      div_den   = rate_eff;
      unique case (state_ff)
         ST_TONE_GO: begin
            div_start = 1'b1;
         end
         ST_RATE_GO: begin
            div_start = 1'b1;
            div_num   = NumW'(rate_eff);
            div_den   = RW'(sib_ff);
         end
         ST_PHASE_GO: begin
            div_start = 1'b1;
            div_num   = NumW'({prod_ff, 1'b0}) + NumW'(f_nb);
            div_den   = RW'({f_nb, 1'b0});
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   // date digits: tens by reciprocal multiply
   always_comb begin
      date_j = format_ff ? 3'(msg_idx - MbiW'(2)) : 3'(msg_idx - MbiW'(4));
      unique case (date_j[2:1])
         2'd0: date_v = month_ff;
         2'd1: date_v = day_ff;
         2'd2: date_v = hour_ff;
         2'd3: date_v = minute_ff;
      endcase
      date_prod = 15'(date_v) * 15'd205;
      date_tens = date_prod[14:11];
      date_ones = date_v - 7'(7'(date_tens) * 7'd10);
      date_char = cidg_pkg::ASCII_ZERO + (date_j[0] ? 8'(date_ones) : 8'(date_tens));
   end

   // message byte at the current slot
   always_comb begin
      priority if (msg_idx >= msg_len) begin
         byte_val = 8'h00;
      end else if (msg_idx == msg_len - MbiW'(1)) begin
         byte_val = 8'h00 - csum_ff;
      end else if (format_ff) begin
         priority if (msg_idx == MbiW'(0)) byte_val = cidg_pkg::SDMF_TYPE;
         else if (msg_idx == MbiW'(1)) byte_val = 8'(msg_len - MbiW'(3));
         else if (msg_idx < MbiW'(10)) byte_val = date_char;
         else byte_val = num_rdata;
      end else begin
         priority if (msg_idx == MbiW'(0)) byte_val = cidg_pkg::MDMF_TYPE;
         else if (msg_idx == MbiW'(1)) byte_val = 8'(msg_len - MbiW'(3));
         else if (msg_idx == MbiW'(2)) byte_val = cidg_pkg::PARAM_DATE;
         else if (msg_idx == MbiW'(3)) byte_val = cidg_pkg::DATE_LEN;
         else if (msg_idx < MbiW'(12)) byte_val = date_char;
         else if (msg_idx == MbiW'(12)) byte_val = cidg_pkg::PARAM_NUMBER;
         else if (msg_idx == MbiW'(13)) byte_val = 8'(num_len_ff);
         else if (msg_idx < MbiW'(14) + MbiW'(num_len_ff)) byte_val = num_rdata;
         else if (name_pos == MbiW'(0)) byte_val = cidg_pkg::PARAM_NAME;
         else if (name_pos == MbiW'(1)) byte_val = 8'(name_len_ff);
         else byte_val = name_rdata;
      end
   end

   // line bit at the current slot and frame position
   always_comb begin
      preamble_pat = (mbi_ff < MbiW'(cidg_pkg::FIRST_PREAMBLE))
                   ? cidg_pkg::PREAMBLE_A : cidg_pkg::PREAMBLE_B;
      priority if (mbi_ff < MbiW'(cidg_pkg::PREAMBLE_BYTES)) begin
         bit_val = preamble_pat[fbi_ff[2:0]];
      end else if (msg_idx >= msg_len) begin
         bit_val = 1'b0;
      end else if (fbi_ff == 4'd0) begin
         bit_val = 1'b0;
      end else if (fbi_ff >= 4'd9) begin
         bit_val = 1'b1;
      end else begin
         bit_val = byte_val[3'(fbi_ff - 4'd1)];
      end
   end

   assign fbi_inc   = fbi_ff + 4'd1;
   assign fbi_limit = (mbi_ff < MbiW'(cidg_pkg::PREAMBLE_BYTES)) ? 4'd8 : 4'd10;
   assign br_val    = $signed({2'b00, div_quotient[15:0]}) - $signed({2'b00, resid_ff});
   assign res_val   = BitRateS - br_val;

   always_comb begin
      num_len_in    = num_len_ff;
      name_len_in   = name_len_ff;
      count_in      = count_ff;
      mbi_in        = mbi_ff;
      fbi_in        = fbi_ff;
      csum_in       = csum_ff;
      t_in          = t_ff;
      sib_in        = sib_ff;
      resid_in      = resid_ff;
      cur_in        = cur_ff;
      nb_in         = nb_ff;
      prod_in       = prod_ff;
      sample_in     = sample_ff;
      status_in     = status_ff;
      skip_in       = skip_ff;
      state_in      = state_ff;
      kind_in       = kind_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      do_restart    = 1'b0;

      if (csr_write_en) begin
         do_restart = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_chan.opcode)
                  cidg_pkg::OP_CLEAR: begin
                     num_len_in  = '0;
                     name_len_in = '0;
                     do_restart  = 1'b1;
                  end
                  cidg_pkg::OP_APPEND_NUMBER: begin
                     if (num_we) begin
                        num_len_in = num_len_ff + LenW'(1);
                        do_restart = 1'b1;
                     end
                  end
                  cidg_pkg::OP_APPEND_NAME: begin
                     if (name_we) begin
                        name_len_in = name_len_ff + LenW'(1);
                        do_restart  = 1'b1;
                     end
                  end
                  cidg_pkg::OP_TICK: begin
                     sample_in = '0;
                     status_in = 1'b0;
                     skip_in   = 1'b0;
                     priority if (num_len_ff == '0) begin
                        status_in = 1'b1;
                        skip_in   = 1'b1;
                        state_in  = ST_DONE;
                     end else if (!active) begin
                        state_in = ST_DONE;
                     end else if (count_ff == CW'(rate_eff)) begin
                        kind_in  = FK_FIRST;
                        state_in = ST_FETCH;
                     end else begin
                        state_in = ST_MUL;
                     end
                  end
               endcase
            end
         end
         ST_FETCH: begin
            state_in = ST_BYTE;
         end
         ST_BYTE: begin
            unique case (kind_ff)
               FK_FIRST: begin
                  cur_in   = bit_val;
                  state_in = ST_MUL;
               end
               FK_ADVANCE: begin
                  if (fbi_inc >= fbi_limit) begin
                     if (mbi_ff >= MbiW'(cidg_pkg::PREAMBLE_BYTES)) begin
                        csum_in = csum_ff + byte_val;
                     end
                     fbi_in = 4'd0;
                     mbi_in = mbi_ff + MbiW'(1);
                  end else begin
                     fbi_in = fbi_inc;
                  end
                  kind_in  = FK_NEW;
                  state_in = ST_FETCH;
               end
               FK_NEW: begin
                  priority if (bit_val == cur_ff) begin
                     state_in = ST_DONE;
                  end else if (f_bit == '0) begin
                     t_in     = '0;
                     cur_in   = bit_val;
                     state_in = ST_DONE;
                  end else begin
                     nb_in    = bit_val;
                     state_in = ST_MUL_PHASE;
                  end
               end
            endcase
         end
         ST_MUL: begin
            prod_in  = 30'(t_ff) * 30'(f_cur);
            state_in = ST_TONE_GO;
         end
         ST_TONE_GO: begin
            state_in = ST_TONE_WAIT;
         end
         ST_TONE_WAIT: begin
            if (div_done) begin
               sample_in = rom_value;
               t_in      = t_ff + TW'(1);
               sib_in    = (sib_ff == 8'hFF) ? 8'hFF : sib_ff + 8'd1;
               state_in  = ST_RATE_GO;
            end
         end
         ST_RATE_GO: begin
            state_in = ST_RATE_WAIT;
         end
         ST_RATE_WAIT: begin
            if (div_done) begin
               if (br_val <= BitRateS) begin
                  resid_in = (res_val > 18'sd65535) ? 16'hFFFF : res_val[15:0];
                  sib_in   = 8'd0;
                  kind_in  = FK_ADVANCE;
                  state_in = ST_FETCH;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_MUL_PHASE: begin
            prod_in  = 30'(t_ff) * 30'(f_cur);
            state_in = ST_PHASE_GO;
         end
         ST_PHASE_GO: begin
            state_in = ST_PHASE_WAIT;
         end
         ST_PHASE_WAIT: begin
            if (div_done) begin
               t_in     = div_quotient[TW-1:0];
               cur_in   = nb_ff;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = sample_ff;
               rsp_status_in = status_ff;
               rsp_last_in   = !skip_ff && (count_next >= total);
               if (!skip_ff) begin
                  count_in = count_next;
                  if (count_next >= total) begin
                     do_restart = 1'b1;
                  end
               end
               state_in = ST_IDLE;
            end
         end
      endcase

      // buffer restarts from its first sample
      if (do_restart) begin
         count_in = '0;
         mbi_in   = '0;
         fbi_in   = '0;
         csum_in  = '0;
         t_in     = '0;
         sib_in   = '0;
         resid_in = '0;
         cur_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff    <= 1'b0;
         month_ff     <= 7'd1;
         day_ff       <= 7'd1;
         hour_ff      <= 7'd0;
         minute_ff    <= 7'd0;
         rate_cfg_ff  <= RW'(8000);
         mark_ff      <= FW'(1200);
         space_ff     <= FW'(2200);
         num_len_ff   <= '0;
         name_len_ff  <= '0;
         count_ff     <= '0;
         mbi_ff       <= '0;
         fbi_ff       <= '0;
         csum_ff      <= '0;
         t_ff         <= '0;
         sib_ff       <= '0;
         resid_ff     <= '0;
         cur_ff       <= 1'b0;
         state_ff     <= ST_IDLE;
         kind_ff      <= FK_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               cidg_pkg::CSR_FORMAT_MODE: format_ff   <= csr_write_data[0];
               cidg_pkg::CSR_MONTH:       month_ff    <= csr_write_data[6:0];
               cidg_pkg::CSR_DAY:         day_ff      <= csr_write_data[6:0];
               cidg_pkg::CSR_HOUR:        hour_ff     <= csr_write_data[6:0];
               cidg_pkg::CSR_MINUTE:      minute_ff   <= csr_write_data[6:0];
               cidg_pkg::CSR_SAMPLE_RATE: rate_cfg_ff <= csr_write_data;
               cidg_pkg::CSR_MARK_FREQ:   mark_ff     <= csr_write_data[FW-1:0];
               cidg_pkg::CSR_SPACE_FREQ:  space_ff    <= csr_write_data[FW-1:0];
            endcase
         end
         num_len_ff   <= num_len_in;
         name_len_ff  <= name_len_in;
         count_ff     <= count_in;
         mbi_ff       <= mbi_in;
         fbi_ff       <= fbi_in;
         csum_ff      <= csum_in;
         t_ff         <= t_in;
         sib_ff       <= sib_in;
         resid_ff     <= resid_in;
         cur_ff       <= cur_in;
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      nb_ff         <= nb_in;
      prod_ff       <= prod_in;
      sample_ff     <= sample_in;
      status_ff     <= status_in;
      skip_ff       <= skip_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.sample_value = rsp_sample_ff;
   assign rsp_chan.last_sample  = rsp_last_ff;
   assign rsp_chan.status_code  = rsp_status_ff;

   `CIDG_ASSERT_IMPLIES(a_div_start_free, clock, reset, div_start, !div_busy)
   `CIDG_ASSERT_IMPLIES(a_rate_div_nonzero, clock, reset, state_ff == ST_RATE_GO, sib_ff != 8'd0)
   `CIDG_ASSERT_IMPLIES(a_status_silent, clock, reset, rsp_valid_ff && rsp_status_ff, rsp_sample_ff == '0 && !rsp_last_ff)
   `CIDG_ASSERT_IMPLIES(a_frame_bound, clock, reset, state_ff != ST_IDLE, fbi_ff < 4'd10)
   `CIDG_ASSERT_NEXT(a_div_done_pulse, clock, reset, div_done, !div_done)
endmodule

FILE: bench/cidg_sample_checker.sv
// sample checker: watches the channels, predicts each sample and compares it
module cidg_sample_checker (
   input  logic                             clock,
   input  logic                             reset,
   cidg_req_if                              req,
   cidg_rsp_if                              rsp,
   input  logic                             csr_write_en,
   input  logic [cidg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cidg_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output int                               fail_count,
   output int                               pending,
   output int                               checked
);
   localparam int CAPACITY = 32;
   localparam int LINE_RATE = 1200;
   localparam longint HALF_PI_Q30 = 64'd1686629713;

   typedef struct {
      logic signed [cidg_pkg::SAMPLE_W-1:0] sample;
      logic                                 last;
      logic                                 status;
   } sample_type;

   sample_type want_q[$];
   int         quarter_tab[256];

   // register copy
   logic        fmt_sdmf;
   logic [6:0]  month_v, day_v, hour_v, minute_v;
   logic [15:0] rate_hz;
   logic [11:0] mark_hz, space_hz;

   // generator state
   logic [7:0]  number_chars[CAPACITY];
   logic [7:0]  name_chars[CAPACITY];
   int unsigned num_len, name_len;
   int unsigned sample_idx, byte_slot, frame_bit, byte_sum, phase_t, bit_samples;
   int          residual;
   logic        tone_bit;

   function automatic int quarter_sine(int unsigned r);
      longint          theta, term, total;
      longint unsigned th2;
      longint unsigned mag;
      theta = (longint'(r) * HALF_PI_Q30) / 256;
      th2 = (longint'(theta) * longint'(theta)) >> 30;
      term = theta;
      total = theta;
      for (int n = 1; n <= 7; n++) begin
         term = longint'((longint'(term) * longint'(th2)) >> 30) / ((2 * n) * (2 * n + 1));
         total = (n % 2 == 1) ? total - term : total + term;
      end
      if (total < 0) total = 0;
      mag = (64'd8191 * longint'(total)) >> 30;
      if (mag > 8191) mag = 8191;
      return int'(mag);
   endfunction

   function automatic int sine_at(logic [9:0] idx);
      int unsigned q, r;
      int mag;
      q = idx / 256;
      r = idx % 256;
      if (q % 2 == 1) mag = (r == 0) ? cidg_pkg::AMPLITUDE : quarter_tab[256 - r];
      else mag = quarter_tab[r];
      return (q >= 2) ? -mag : mag;
   endfunction

   function automatic int unsigned message_len();
      if (fmt_sdmf) return 11 + num_len;
      return 15 + num_len + ((name_len != 0) ? name_len + 2 : 0);
   endfunction

   function automatic logic [7:0] date_char(int unsigned j);
      int unsigned v;
      v = (j < 2) ? month_v : (j < 4) ? day_v : (j < 6) ? hour_v : minute_v;
      return 8'(((j % 2 == 1) ? v % 10 : v / 10) + cidg_pkg::ASCII_ZERO);
   endfunction

   function automatic logic [7:0] message_byte(int unsigned m);
      int unsigned p;
      if (m >= message_len()) return 8'h00;
      if (m == message_len() - 1) return 8'(0 - byte_sum);
      if (fmt_sdmf) begin
         if (m == 0) return cidg_pkg::SDMF_TYPE;
         if (m == 1) return 8'(8 + num_len);
         if (m < 10) return date_char(m - 2);
         return number_chars[(m - 10) % CAPACITY];
      end
      if (m == 0) return cidg_pkg::MDMF_TYPE;
      if (m == 1) return 8'(12 + num_len + ((name_len != 0) ? name_len + 2 : 0));
      if (m == 2) return cidg_pkg::PARAM_DATE;
      if (m == 3) return cidg_pkg::DATE_LEN;
      if (m < 12) return date_char(m - 4);
      if (m == 12) return cidg_pkg::PARAM_NUMBER;
      if (m == 13) return 8'(num_len);
      if (m < 14 + num_len) return number_chars[(m - 14) % CAPACITY];
      p = m - 14 - num_len;
      if (p == 0) return cidg_pkg::PARAM_NAME;
      if (p == 1) return 8'(name_len);
      return name_chars[(p - 2) % CAPACITY];
   endfunction

   function automatic logic stream_bit();
      logic [7:0] b;
      int unsigned m;
      if (byte_slot < cidg_pkg::PREAMBLE_BYTES) begin
         b = (byte_slot < cidg_pkg::FIRST_PREAMBLE) ? cidg_pkg::PREAMBLE_A
                                                     : cidg_pkg::PREAMBLE_B;
         return b[frame_bit % 8];
      end
      m = byte_slot - cidg_pkg::PREAMBLE_BYTES;
      if (m >= message_len()) return 1'b0;
      if (frame_bit == 0) return 1'b0;
      if (frame_bit >= 9) return 1'b1;
      b = message_byte(m);
      return b[frame_bit - 1];
   endfunction

   function automatic void next_bit();
      int unsigned lim;
      lim = (byte_slot < cidg_pkg::PREAMBLE_BYTES) ? 8 : 10;
      frame_bit++;
      if (frame_bit >= lim) begin
         if (byte_slot >= cidg_pkg::PREAMBLE_BYTES)
            byte_sum = (byte_sum + message_byte(byte_slot - cidg_pkg::PREAMBLE_BYTES))
                       & 8'hFF;
         frame_bit = 0;
         byte_slot++;
      end
   endfunction

   function automatic void restart_buffer();
      sample_idx = 0;
      byte_slot = 0;
      frame_bit = 0;
      byte_sum = 0;
      phase_t = 0;
      bit_samples = 0;
      residual = 0;
      tone_bit = 1'b0;
   endfunction

   function automatic sample_type next_sample();
      sample_type r;
      int unsigned rate, total, k, f;
      int br, res, sval;
      logic nb;
      longint unsigned ph, fold, fnew;
      r.sample = '0;
      r.last = 1'b0;
      r.status = 1'b0;
      sval = 0;
      if (num_len == 0) begin
         r.status = 1'b1;
         return r;
      end
      rate = (rate_hz != 0) ? rate_hz : 1;
      total = 5 * rate;
      k = sample_idx;
      if (k >= rate && byte_slot < cidg_pkg::PREAMBLE_BYTES + message_len()) begin
         if (k == rate) tone_bit = stream_bit();
         f = tone_bit ? mark_hz : space_hz;
         ph = ((longint'(phase_t) * f) << 10) / rate;
         sval = sine_at(ph[9:0]);
         phase_t = (phase_t + 1) & 18'h3FFFF;
         if (bit_samples < 255) bit_samples++;
         br = int'(rate / bit_samples) - residual;
         if (br <= LINE_RATE) begin
            res = LINE_RATE - br;
            residual = (res > 65535) ? 65535 : res;
            bit_samples = 0;
            next_bit();
            nb = stream_bit();
            if (nb != tone_bit) begin
               fold = tone_bit ? mark_hz : space_hz;
               tone_bit = nb;
               fnew = tone_bit ? mark_hz : space_hz;
               // phase rescaled so the tone stays continuous
               if (fnew == 0) phase_t = 0;
               else phase_t = int'(((2 * longint'(phase_t) * fold + fnew) / (2 * fnew))
                                   & 18'h3FFFF);
            end
         end
      end
      r.last = (k + 1 >= total);
      sample_idx = k + 1;
      if (sample_idx >= total) restart_buffer();
      r.sample = sval[cidg_pkg::SAMPLE_W-1:0];
      return r;
   endfunction

   initial begin
      for (int i = 0; i < 256; i++) quarter_tab[i] = quarter_sine(i);
   end

   always @(posedge clock) begin
      sample_type want, got;
      if (reset) begin
         fmt_sdmf = 1'b0;
         month_v = 7'd1;
         day_v = 7'd1;
         hour_v = 7'd0;
         minute_v = 7'd0;
         rate_hz = 16'd8000;
         mark_hz = 12'd1200;
         space_hz = 12'd2200;
         num_len = 0;
         name_len = 0;
         restart_buffer();
         want_q.delete();
         fail_count = 0;
         checked = 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               cidg_pkg::CSR_FORMAT_MODE: fmt_sdmf = csr_write_data[0];
               cidg_pkg::CSR_MONTH:       month_v = csr_write_data[6:0];
               cidg_pkg::CSR_DAY:         day_v = csr_write_data[6:0];
               cidg_pkg::CSR_HOUR:        hour_v = csr_write_data[6:0];
               cidg_pkg::CSR_MINUTE:      minute_v = csr_write_data[6:0];
               cidg_pkg::CSR_SAMPLE_RATE: rate_hz = csr_write_data;
               cidg_pkg::CSR_MARK_FREQ:   mark_hz = csr_write_data[11:0];
               cidg_pkg::CSR_SPACE_FREQ:  space_hz = csr_write_data[11:0];
               default: ;
            endcase
            restart_buffer();
         end
         // results first: an item accepted on this edge cannot answer on it
         if (rsp.valid && rsp.ready) begin
            got.sample = rsp.sample_value;
            got.last = rsp.last_sample;
            got.status = rsp.status_code;
            checked++;
            if (want_q.size() == 0) begin
               $display("%0t: unexpected sample %0d last %0b status %0b", $time,
                        got.sample, got.last, got.status);
               fail_count++;
            end else begin
               want = want_q.pop_front();
               if (got.sample !== want.sample) begin
                  $display("%0t: sample_value expected %0d got %0d", $time,
                           want.sample, got.sample);
                  fail_count++;
               end
               if (got.last !== want.last) begin
                  $display("%0t: last_sample expected %0b got %0b", $time,
                           want.last, got.last);
                  fail_count++;
               end
               if (got.status !== want.status) begin
                  $display("%0t: status_code expected %0b got %0b", $time,
                           want.status, got.status);
                  fail_count++;
               end
            end
         end
         if (req.valid && req.ready) begin
            case (req.opcode)
               cidg_pkg::OP_CLEAR: begin
                  num_len = 0;
                  name_len = 0;
                  restart_buffer();
               end
               cidg_pkg::OP_APPEND_NUMBER: if (num_len < CAPACITY) begin
                  number_chars[num_len] = req.char_code;
                  num_len++;
                  restart_buffer();
               end
               cidg_pkg::OP_APPEND_NAME: if (name_len < CAPACITY) begin
                  name_chars[name_len] = req.char_code;
                  name_len++;
                  restart_buffer();
               end
               default: want_q.push_back(next_sample());
            endcase
         end
      end
      pending = want_q.size();
   end
endmodule

FILE: bench/tb_caller_id_fsk_generator_unit.sv
// testbench top: stimulus, register phases, idling and verdict
module tb_caller_id_fsk_generator_unit;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int PHASES = 10;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [cidg_pkg::CSR_IDX_W-1:0] csr_index;
   logic [cidg_pkg::CSR_DATA_W-1:0] csr_write_data;
   int fail_count, pending, checked;
   int cycle_count = 0;
   int items_sent;
   logic quiet;

   cidg_req_if req_chan ();
   cidg_rsp_if rsp_chan ();

   caller_id_fsk_generator_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   cidg_sample_checker sample_check (
      .clock          (clock),
      .reset          (reset),
      .req            (req_chan),
      .rsp            (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .fail_count     (fail_count),
      .pending        (pending),
      .checked        (checked)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   // receiver: short random stalls, plus one long hold so the block backs up
   initial begin
      int n, rx_cycles;
      bit held;
      rx_cycles = 0;
      held = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rx_cycles++;
         if (!held && rx_cycles >= 20000) begin
            held = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (400) @(posedge clock);
            rx_cycles += 400;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_chan.ready <= 1'b0;
            n = $urandom_range(1, 3);
            repeat (n) @(posedge clock);
            rx_cycles += n;
         end
         rsp_chan.ready <= 1'b1;
      end
   end

   task automatic send_item(logic [cidg_pkg::OPCODE_W-1:0] op,
                            logic [cidg_pkg::CHAR_W-1:0] ch);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 3);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.opcode <= op;
      req_chan.char_code <= ch;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      // appends leave no result, so give the block time to settle
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(logic [cidg_pkg::CSR_IDX_W-1:0] idx,
                            logic [cidg_pkg::CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
   endtask

   initial begin
      int unsigned rates[PHASES] = '{1, 0, 7, 180, 10, 65535, 60, 250, 2400, 12};
      int ticks[PHASES] = '{12, 15, 40, 910, 55, 25, 30, 30, 25, 65};
      int nlen, alen, date_v;
      logic [cidg_pkg::CSR_DATA_W-1:0] mark_v, space_v;

      quiet = 1'b0;
      items_sent = 0;
      reset <= 1'b1;
      csr_write_en <= 1'b0;
      csr_index <= cidg_pkg::CSR_FORMAT_MODE;
      csr_write_data <= '0;
      req_chan.valid <= 1'b0;
      req_chan.opcode <= cidg_pkg::OP_CLEAR;
      req_chan.char_code <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: no number loaded, name only, then extreme characters and a clear
      send_item(cidg_pkg::OP_TICK, 8'h00);
      send_item(cidg_pkg::OP_TICK, 8'hFF);
      send_item(cidg_pkg::OP_APPEND_NAME, 8'h41);
      send_item(cidg_pkg::OP_TICK, 8'h00);
      send_item(cidg_pkg::OP_APPEND_NUMBER, 8'h00);
      send_item(cidg_pkg::OP_APPEND_NUMBER, 8'hFF);
      send_item(cidg_pkg::OP_APPEND_NAME, 8'h80);
      send_item(cidg_pkg::OP_APPEND_NAME, 8'h7F);
      repeat (4) send_item(cidg_pkg::OP_TICK, 8'hAA);
      send_item(cidg_pkg::OP_CLEAR, 8'hFF);
      send_item(cidg_pkg::OP_TICK, 8'h55);
      send_item(cidg_pkg::OP_APPEND_NUMBER, 8'h35);
      repeat (4) send_item(cidg_pkg::OP_TICK, 8'h00);
      wait_drained();

      for (int p = 0; p < PHASES; p++) begin
         if (p == PHASES - 1) quiet = 1'b1;
         date_v = (p == 0) ? 0 : (p == 1) ? 127 : -1;
         write_reg(cidg_pkg::CSR_FORMAT_MODE,
                   (p < 2) ? 16'(p) : 16'($urandom_range(0, 1)));
         write_reg(cidg_pkg::CSR_MONTH,
                   16'((date_v >= 0) ? date_v : $urandom_range(0, 127)));
         write_reg(cidg_pkg::CSR_DAY,
                   16'((date_v >= 0) ? date_v : $urandom_range(0, 127)));
         write_reg(cidg_pkg::CSR_HOUR,
                   16'((date_v >= 0) ? date_v : $urandom_range(0, 127)));
         write_reg(cidg_pkg::CSR_MINUTE,
                   16'((date_v >= 0) ? date_v : $urandom_range(0, 127)));
         write_reg(cidg_pkg::CSR_SAMPLE_RATE, 16'(rates[p]));
         mark_v = 16'($urandom_range(300, 4000));
         space_v = 16'($urandom_range(300, 4000));
         if (p == 2) begin
            mark_v = 16'd4095;
            space_v = 16'd4095;
         end else if (p == 4) space_v = 16'd0;
         else if (p == 5) mark_v = 16'd0;
         else if (p == 7) begin
            mark_v = 16'($urandom_range(0, 4095));
            space_v = 16'($urandom_range(0, 4095));
         end else if (p == 3) begin
            mark_v = 16'd1200;
            space_v = 16'd2200;
         end
         write_reg(cidg_pkg::CSR_MARK_FREQ, mark_v);
         write_reg(cidg_pkg::CSR_SPACE_FREQ, space_v);
         csr_write_en <= 1'b0;

         // load a caller: overlong strings in some phases test the full store
         nlen = (p == 6) ? 34 : $urandom_range(1, 12);
         alen = (p % 3 == 0) ? 0 : (p == 7) ? 34 : $urandom_range(1, 10);
         send_item(cidg_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
         repeat (nlen) send_item(cidg_pkg::OP_APPEND_NUMBER, 8'($urandom_range(0, 255)));
         repeat (alen) send_item(cidg_pkg::OP_APPEND_NAME, 8'($urandom_range(0, 255)));
         for (int t = 0; t < ticks[p]; t++) begin
            if (p != 3 && p != PHASES - 1 && $urandom_range(0, 40) == 0)
               send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            else
               send_item(cidg_pkg::OP_TICK, 8'($urandom_range(0, 255)));
         end
         wait_drained();
      end

      $display("covered %0d register phases, %0d items sent, %0d samples checked",
               PHASES, items_sent, checked);
      $display("rates from zero to 65535, both message formats, zero and extreme tones");
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

FILE: caller_id_fsk_generator_unit.f
+incdir+hw/rtl
hw/rtl/cidg_pkg.sv
hw/rtl/cidg_if.sv
hw/rtl/cidg_ram.sv
hw/rtl/cidg_divider.sv
hw/rtl/cidg_sine_rom.sv
hw/rtl/caller_id_fsk_generator_unit.sv
bench/cidg_sample_checker.sv
bench/tb_caller_id_fsk_generator_unit.sv
